// File: hw/rtl/gbal_pkg.sv
// Shared types, widths and constants of the greedy bandit action learner.
// No dependencies; every other file of the block imports this package.
package gbal_pkg;

   // Table size and value formats
   localparam int ACTION_COUNT = 16;
   localparam int IDX_W        = $clog2(ACTION_COUNT);
   localparam int VAL_W        = 32;
   localparam int RATE_W       = 16;
   localparam int ACT_W        = 4;
   localparam int FRAC_W       = 16;

   // Update arithmetic widths
   localparam int PROD_W  = VAL_W + RATE_W + 2;
   localparam int SUM_W   = PROD_W + 1;
   localparam int SHIFT_W = SUM_W - FRAC_W;

   // Stream payload widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 1;

   // Control register map
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_PENALTY = 1'd1;

   localparam logic [RATE_W-1:0]       LEARN_RATE_RST     = 16'd6554;
   localparam logic signed [VAL_W-1:0] REPEAT_PENALTY_RST = -32'sd655360;

   // Controller to datapath commands
   typedef struct packed {
      logic start;     // latch reward, begin scan at entry 0
      logic scan_step; // compare one more entry
      logic mul_en;    // pick reward, form both products
      logic commit;    // write table, last action, result register
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan_last; // current entry is the last of the table
      logic out_free;  // result register can take a new transaction
   } dp_sts_type;

   // Reset contents of the value table: entry j = j, entry 0 = 25.0
   function automatic logic signed [VAL_W-1:0] init_value(input logic [IDX_W-1:0] idx);
      logic signed [VAL_W-1:0] v;
      v = VAL_W'(idx) << FRAC_W;
      if (idx == '0) begin
         v = 32'sd25 <<< FRAC_W;
      end
      return v;
   endfunction

endpackage

// File: hw/rtl/gbal_ctrl.sv
// Sequencer of the greedy bandit action learner: accept, scan, multiply, commit.
// Depends on gbal_pkg for the command and status structs.
module gbal_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  gbal_pkg::dp_sts_type sts,
   output gbal_pkg::dp_cmd_type cmd
);
   import gbal_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_SUM  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            // hold here while the previous result is still unread
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/gbal_dp.sv
// Datapath of the greedy bandit action learner: value table, argmax scan,
// blend multipliers, rounding, control registers and the result register.
// Depends on gbal_pkg.
module gbal_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gbal_pkg::dp_cmd_type                  cmd,
   output gbal_pkg::dp_sts_type                  sts,
   input  logic signed [gbal_pkg::VAL_W-1:0]     reward_in,
   input  logic                                  csr_we,
   input  logic [gbal_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gbal_pkg::CSR_DAT_W-1:0]        csr_wdata,
   input  logic                                  rsp_tready,
   output logic                                  rsp_valid,
   output logic [gbal_pkg::ACT_W-1:0]            rsp_action,
   output logic signed [gbal_pkg::VAL_W-1:0]     rsp_value,
   output logic                                  rsp_repeat
);
   import gbal_pkg::*;

   localparam logic signed [SHIFT_W-1:0] VMAX = SHIFT_W'(signed'(32'h7FFF_FFFF));
   localparam logic signed [SHIFT_W-1:0] VMIN = SHIFT_W'(signed'(32'h8000_0000));
   localparam logic signed [SUM_W-1:0]   HALF = SUM_W'(1) <<< (FRAC_W - 1);
   localparam logic [RATE_W:0]           ONE  = (RATE_W+1)'(1) << FRAC_W;

   logic signed [VAL_W-1:0]  table_ff [ACTION_COUNT];
   logic [IDX_W-1:0]         last_ff;
   logic [IDX_W-1:0]         best_ff;
   logic signed [VAL_W-1:0]  best_val_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic signed [VAL_W-1:0]  reward_ff;
   logic                     rep_ff;
   logic signed [PROD_W-1:0] prod_a_ff;
   logic signed [PROD_W-1:0] prod_b_ff;
   logic [RATE_W-1:0]        rate_ff;
   logic signed [VAL_W-1:0]  penalty_ff;
   logic                     out_valid_ff;
   logic [ACT_W-1:0]         out_action_ff;
   logic signed [VAL_W-1:0]  out_value_ff;
   logic                     out_repeat_ff;

   logic signed [VAL_W-1:0]  cand_val;
   logic                     rep_in;
   logic signed [VAL_W-1:0]  eff_reward;
   logic [RATE_W:0]          comp_rate;
   logic signed [PROD_W-1:0] prod_a_in;
   logic signed [PROD_W-1:0] prod_b_in;
   logic signed [SUM_W-1:0]  sum;
   logic signed [SHIFT_W-1:0] shifted;
   logic signed [VAL_W-1:0]  new_val;
   logic [7:0]               best_wide;

   assign sts.scan_last = (idx_ff == IDX_W'(ACTION_COUNT - 1));
   assign sts.out_free  = !out_valid_ff || rsp_tready;

   // Scan candidate
   assign cand_val = table_ff[idx_ff];

   // Reward choice and the two blend products
   assign rep_in     = (best_ff == last_ff);
   assign eff_reward = rep_in ? penalty_ff : reward_ff;
   assign comp_rate  = ONE - (RATE_W+1)'(rate_ff);
   assign prod_a_in  = $signed({1'b0, comp_rate}) * best_val_ff;
   assign prod_b_in  = $signed({1'b0, rate_ff}) * eff_reward;

   // Sum, round half up, floor shift, clamp
   always_comb begin
      sum     = SUM_W'(prod_a_ff) + SUM_W'(prod_b_ff) + HALF;
      shifted = SHIFT_W'(sum >>> FRAC_W);
      if (shifted > VMAX) begin
         new_val = VMAX[VAL_W-1:0];
      end else if (shifted < VMIN) begin
         new_val = VMIN[VAL_W-1:0];
      end else begin
         new_val = shifted[VAL_W-1:0];
      end
   end

   assign best_wide = 8'(best_ff);

   // Value table and last action
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < ACTION_COUNT; j++) begin
            table_ff[j] <= init_value(IDX_W'(j));
         end
         last_ff <= '0;
      end else if (cmd.commit) begin
         table_ff[best_ff] <= new_val;
         last_ff           <= best_ff;
      end
   end

   // Argmax scan, lowest index wins ties
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         reward_ff   <= reward_in;
         best_ff     <= '0;
         best_val_ff <= table_ff[0];
         idx_ff      <= IDX_W'(1);
      end else if (cmd.scan_step) begin
         if (cand_val > best_val_ff) begin
            best_ff     <= idx_ff;
            best_val_ff <= cand_val;
         end
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   // Product registers
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
         rep_ff    <= rep_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff    <= LEARN_RATE_RST;
         penalty_ff <= REPEAT_PENALTY_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LEARN_RATE:     rate_ff    <= csr_wdata[RATE_W-1:0];
            CSR_REPEAT_PENALTY: penalty_ff <= signed'(csr_wdata[VAL_W-1:0]);
            default: ;
         endcase
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_action_ff <= best_wide[ACT_W-1:0];
         out_value_ff  <= new_val;
         out_repeat_ff <= rep_ff;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_action = out_action_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_repeat = out_repeat_ff;

endmodule

// File: hw/rtl/greedy_bandit_action_learner.sv
// Top level of the greedy bandit action learner: joins sequencer and datapath.
// Depends on gbal_pkg, gbal_ctrl and gbal_dp.
//
//  port group   dir   payload
//  req_*        in    tdata[31:0] observed_reward
//  rsp_*        out   tdata[3:0] chosen_action, [35:4] updated_value; tuser[0] was_repeat
//  csr_*        in    index 0 learn_rate, index 1 repeat_penalty
//
// After the accept the scan compares table entries 1 to ACTION_COUNT - 1 against entry 0,
// one table entry per cycle, then a multiply state and a commit state follow; the commit
// waits while the previous result is unread. The sequencer returns to idle with the commit,
// so a new request is taken only once the previous one has committed.
// Reset is synchronous and restores the table, last action and registers.
// A stalled rsp side holds the finished result and blocks the commit of the next.
module greedy_bandit_action_learner (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [gbal_pkg::REQ_DATA_W-1:0]      req_tdata,  // [31:0] observed_reward
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [gbal_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [3:0] action, [35:4] value
   output logic [gbal_pkg::RSP_USER_W-1:0]      rsp_tuser,  // [0] was_repeat
   input  logic                                 csr_we,
   input  logic [gbal_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gbal_pkg::CSR_DAT_W-1:0]       csr_wdata
);
   import gbal_pkg::*;

   dp_cmd_type              cmd;
   dp_sts_type              sts;
   logic [ACT_W-1:0]        rsp_action;
   logic signed [VAL_W-1:0] rsp_value;
   logic                    rsp_repeat;

   gbal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   gbal_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .reward_in  (signed'(req_tdata[VAL_W-1:0])),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_action (rsp_action),
      .rsp_value  (rsp_value),
      .rsp_repeat (rsp_repeat)
   );

   // Pack result fields, zero fill to whole bytes
   assign rsp_tdata = {(RSP_DATA_W - ACT_W - VAL_W)'(0), rsp_value, rsp_action};
   assign rsp_tuser = rsp_repeat;

endmodule

// File: hw/rtl/gbal_chk.sv
// Port-level checks of the greedy bandit action learner, bound to the top level.
// Depends on gbal_pkg and greedy_bandit_action_learner.
module gbal_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gbal_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [gbal_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import gbal_pkg::*;

   // No result survives a reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // One request at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // A new result appears only as the sequencer returns to idle
   a_result_on_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result loaded while still busy");

   // Padding bits of the result are zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:ACT_W+VAL_W] == '0)
      else $error("nonzero padding in result");

endmodule

bind greedy_bandit_action_learner gbal_chk u_gbal_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: test/gbal_learn_checker.sv
// Scoreboard for the greedy bandit action learner: watches the req, rsp and csr ports,
// predicts every result from its own copy of the value table, and compares in order.
// Depends on gbal_pkg for widths and register indexes.
module gbal_learn_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [gbal_pkg::REQ_DATA_W-1:0] req_tdata,  // [31:0] observed_reward
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [gbal_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [3:0] chosen_action, [35:4] updated_value
   input  logic [gbal_pkg::RSP_USER_W-1:0] rsp_tuser,  // [0] was_repeat
   input  logic                            csr_we,
   input  logic [gbal_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gbal_pkg::CSR_DAT_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import gbal_pkg::*;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [VAL_W-1:0] value;
      logic             was_rep;
   } pick_type;

   // Shadow copy of the block's state and registers
   logic signed [VAL_W-1:0] q_table [ACTION_COUNT];
   logic [IDX_W-1:0]        last_pick;
   logic [RATE_W-1:0]       alpha;
   logic signed [VAL_W-1:0] penalty;

   pick_type pending_picks[$];
   pick_type want;
   pick_type got;
   int       fails   = 0;
   int       waiting = 0;

   assign fail_count    = fails;
   assign pending_count = waiting;

   function automatic void restore_state();
      for (int j = 0; j < ACTION_COUNT; j++) begin
         q_table[j] = VAL_W'(j) << FRAC_W;
      end
      q_table[0]  = 32'sd25 <<< FRAC_W;
      last_pick   = '0;
      alpha       = LEARN_RATE_RST;
      penalty     = REPEAT_PENALTY_RST;
   endfunction

   // One learning step: greedy pick (lowest index wins ties), reward swap on a
   // repeat, blend (1-alpha)*Q + alpha*reward rounded half up, clamp to 32 bits.
   function automatic pick_type learn_step(input logic [REQ_DATA_W-1:0] reward_in);
      pick_type                res;
      int                      best;
      logic                    rep;
      logic signed [VAL_W-1:0] rwd;
      longint                  q;
      longint                  acc;
      longint                  nv;
      best = 0;
      for (int i = 1; i < ACTION_COUNT; i++) begin
         if (q_table[i] > q_table[best]) best = i;
      end
      rep = (IDX_W'(best) == last_pick);
      rwd = rep ? penalty : $signed(reward_in[VAL_W-1:0]);
      q   = q_table[best];
      acc = (longint'(65536) - longint'(alpha)) * q + longint'(alpha) * longint'(rwd);
      nv  = (acc + 64'sd32768) >>> FRAC_W;
      if (nv > longint'(32'sh7FFF_FFFF)) nv = longint'(32'sh7FFF_FFFF);
      if (nv < -longint'(64'sd2147483648)) nv = -longint'(64'sd2147483648);
      q_table[best] = VAL_W'(nv);
      last_pick     = IDX_W'(best);
      res.action    = ACT_W'(best);
      res.value     = VAL_W'(nv);
      res.was_rep   = rep;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         restore_state();
         pending_picks.delete();
      end else begin
         // register writes are to come only while the block is idle, which the block leaves to the user
         if (csr_we) begin
            if (csr_index == CSR_LEARN_RATE) alpha = csr_wdata[RATE_W-1:0];
            else if (csr_index == CSR_REPEAT_PENALTY) penalty = csr_wdata[VAL_W-1:0];
         end
         if (req_tvalid && req_tready) begin
            pending_picks.push_back(learn_step(req_tdata));
         end
         // compare each rsp transaction with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.action  = rsp_tdata[ACT_W-1:0];
            got.value   = rsp_tdata[ACT_W +: VAL_W];
            got.was_rep = rsp_tuser[0];
            if (pending_picks.size() == 0) begin
               $display("%0t: unexpected result, actual action %0d value %0d repeat %0d",
                        $time, got.action, $signed(got.value), got.was_rep);
               fails++;
            end else begin
               want = pending_picks.pop_front();
               if (got.action !== want.action) begin
                  $display("%0t: chosen_action expected %0d, actual %0d",
                           $time, want.action, got.action);
                  fails++;
               end
               if (got.value !== want.value) begin
                  $display("%0t: updated_value expected %0d, actual %0d",
                           $time, $signed(want.value), $signed(got.value));
                  fails++;
               end
               if (got.was_rep !== want.was_rep) begin
                  $display("%0t: was_repeat expected %0d, actual %0d",
                           $time, want.was_rep, got.was_rep);
                  fails++;
               end
            end
         end
      end
      waiting = pending_picks.size();
   end

endmodule

// File: test/greedy_bandit_action_learner_tb.sv
// Testbench top for the greedy bandit action learner: clock, reset, reward stimulus,
// rsp back-pressure and register phases; checking is done by gbal_learn_checker.
// Depends on gbal_pkg, greedy_bandit_action_learner and gbal_learn_checker.
module greedy_bandit_action_learner_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gbal_pkg::*;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // [31:0] observed_reward
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [3:0] chosen_action, [35:4] updated_value
   logic [RSP_USER_W-1:0] rsp_tuser;        // [0] was_repeat
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DAT_W-1:0]  csr_wdata  = '0;

   int   fail_count;
   int   pending_count;
   logic no_gaps  = 1'b0;  // streaming phase: neither side idles
   logic hold_rsp = 1'b0;  // request one long rsp stall

   greedy_bandit_action_learner DUT (.*);

   gbal_learn_checker u_check (.*);

   always #2 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] rand_reward();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 5))
               0: return 32'h0000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h8000_0000;
               3: return 32'h0001_0000;
               4: return 32'hFFFF_0000;
               default: return 32'h0019_0000;
            endcase
         end
         default: return $urandom_range(0, 40 << 16) - (20 << 16);
      endcase
   endfunction

   // one req transaction, then an optional gap
   task automatic send_reward(input logic [31:0] reward);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= reward;
      do @(posedge clock); while (!req_tready);
      gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering, let every result drain, then a margin beyond the latency
   task automatic drain();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      wait (pending_count == 0);
      repeat (24) @(posedge clock);
   endtask

   // write both registers on an idle block; upper data bits of the rate are junk
   task automatic apply_config(input logic [RATE_W-1:0] rate, input logic [31:0] pen);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_LEARN_RATE;
      csr_wdata <= {16'($urandom), rate};
      @(posedge clock);
      csr_index <= CSR_REPEAT_PENALTY;
      csr_wdata <= pen;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [RATE_W-1:0] rand_rate();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 16'hFFFF;
         2: return 16'd1;
         default: return RATE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [31:0] rand_penalty();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return $urandom;
         default: return $urandom_range(0, 60 << 16) - (30 << 16);
      endcase
   endfunction

   // rsp side: random stalls, plus one long hold while the sender keeps going
   initial begin
      int stall;
      int run;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         stall = idle_len();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         run = $urandom_range(1, 8);
         repeat (run - 1) @(posedge clock);
      end
   end

   // stimulus and verdict
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default registers; the first step after reset repeats action 0
      send_reward(32'h7FFF_FFFF);
      send_reward(32'h8000_0000);
      send_reward(32'h0000_0000);
      send_reward(32'hFFFF_FFFF);
      send_reward(32'h0000_0001);
      send_reward(32'h0019_0000);
      // largest rate with largest penalty
      apply_config(16'hFFFF, 32'h7FFF_FFFF);
      send_reward(32'h8000_0000);
      send_reward(32'h7FFF_FFFF);
      send_reward(32'h8000_0000);
      send_reward(32'hFFFF_FFFF);
      // zero rate keeps the table frozen; smallest penalty
      apply_config(16'h0000, 32'h8000_0000);
      send_reward(32'h7FFF_FFFF);
      send_reward(32'h8000_0000);
      send_reward(32'h1234_5678);
      // zero rewards at near-unity rate flatten the table into ties
      apply_config(16'hFFFF, 32'h0000_0000);
      repeat (10) send_reward(32'h0000_0000);

      // random phases with fresh registers each time
      for (int ph = 0; ph < 8; ph++) begin
         apply_config(rand_rate(), rand_penalty());
         no_gaps = (ph % 4 == 3);
         for (int n = 0; n < 210; n++) begin
            if (ph == 1 && n == 40) hold_rsp = 1'b1;
            send_reward(rand_reward());
         end
      end
      no_gaps = 1'b0;
      drain();

      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
